[rtl/fast_atan2_degrees_unit_defines.svh]
// Assertion macros shared by the fast atan2 RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef FAST_ATAN2_DEGREES_UNIT_DEFINES_SVH
`define FAST_ATAN2_DEGREES_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FA2D_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FA2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fa2d_pkg.sv]
// Shared types and constants of the fast atan2 unit.
// No dependencies.
package fa2d_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS = FRAC_BITS + 1;   // quotient incl. the 1.0 bit
  localparam int COEF_W = 24;
  localparam int T_W = 26;                 // polynomial accumulator
  localparam int A_W = 28;                 // signed angle after unfolding
  localparam int AU_W = 27;                // clamped angle
  localparam int OUT_W = 24;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P1    = 3'd0,
    REG_P3    = 3'd1,
    REG_P5    = 3'd2,
    REG_P7    = 3'd3,
    REG_SCALE = 3'd4
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] P1_RST = 24'sd3754139;
  localparam logic signed [COEF_W-1:0] P3_RST = -24'sd1223390;
  localparam logic signed [COEF_W-1:0] P5_RST = 24'sd584188;
  localparam logic signed [COEF_W-1:0] P7_RST = -24'sd166443;
  localparam logic [COEF_W-1:0] SCALE_RST = 24'd65536;

  localparam logic signed [A_W-1:0] DEG90  = 28'sd5898240;
  localparam logic signed [A_W-1:0] DEG180 = 28'sd11796480;
  localparam logic signed [A_W-1:0] DEG360 = 28'sd23592960;

  localparam logic [FRAC_BITS-1:0] C_MAX = 16'hFFFF;
  localparam logic [OUT_W-1:0] OUT_MAX = 24'hFFFFFF;

  // Octant info that rides along with each beat
  typedef struct packed {
    logic x_major;
    logic x_neg;
    logic y_neg;
    logic zero;
  } flags_t;

endpackage

[rtl/fa2d_divider.sv]
// Pipelined restoring divider: floor(lo * 2^16 / hi), one quotient bit a stage.
// Depends on fa2d_pkg and the assertion macro header.
`include "fast_atan2_degrees_unit_defines.svh"
module fa2d_divider #(
  parameter int COMPONENT_BITS = fa2d_pkg::COMPONENT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic [COMPONENT_BITS-1:0]     lo,
  input  logic [COMPONENT_BITS-1:0]     hi,
  input  fa2d_pkg::flags_t              in_flags,
  output logic                          out_valid,
  output logic [fa2d_pkg::Q_BITS-1:0]   quot,
  output fa2d_pkg::flags_t              out_flags
);

  localparam int NS = fa2d_pkg::Q_BITS;
  localparam int MW = COMPONENT_BITS;

  logic [MW-1:0]               rem_q [NS];
  logic [MW-1:0]               hi_q  [NS];
  logic [NS-1:0]               q_q   [NS];
  fa2d_pkg::flags_t            fl_q  [NS];
  logic [NS-1:0]               vld;

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic [MW:0]       trial;
      logic              geq;
      logic [MW:0]       diff;
      logic [NS-1:0]     q_in;
      logic [MW-1:0]     hi_in;
      fa2d_pkg::flags_t  fl_in;
      logic              v_in;

      // first stage tests the 1.0 bit, later ones shift the remainder
      if (k == 0) begin : g_first
        assign trial = {1'b0, lo};
        assign q_in  = '0;
        assign hi_in = hi;
        assign fl_in = in_flags;
        assign v_in  = in_valid;
      end else begin : g_next
        assign trial = {rem_q[k-1], 1'b0};
        assign q_in  = q_q[k-1];
        assign hi_in = hi_q[k-1];
        assign fl_in = fl_q[k-1];
        assign v_in  = vld[k-1];
      end

      assign geq  = trial >= {1'b0, hi_in};
      assign diff = trial - {1'b0, hi_in};

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (adv) begin
          vld[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[k] <= geq ? diff[MW-1:0] : trial[MW-1:0];
          q_q[k]   <= {q_in[NS-2:0], geq};
          hi_q[k]  <= hi_in;
          fl_q[k]  <= fl_in;
        end
      end
    end
  endgenerate

  assign out_valid = vld[NS-1];
  assign quot      = q_q[NS-1];
  assign out_flags = fl_q[NS-1];

  // remainder must end below the divisor
  `FA2D_ASSERT_IMPLY(a_rem_below, vld[NS-1] && !fl_q[NS-1].zero, rem_q[NS-1] < hi_q[NS-1], "divider remainder not below divisor")
  // zero pair carries a zero remainder
  `FA2D_ASSERT_IMPLY(a_zero_rem, vld[NS-1] && fl_q[NS-1].zero, rem_q[NS-1] == '0, "zero input left a remainder")
  // a beat in the first stage moves on when the pipe advances
  `FA2D_ASSERT_NEXT(a_advance, adv && vld[0] && !rst, vld[1], "divider lost a beat")

endmodule

[rtl/fast_atan2_degrees_unit.sv]
// Top level of the fast atan2 unit: angle of (x, y) in scaled degrees.
// Depends on fa2d_pkg, fa2d_divider and the assertion macro header.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata = x_value, y_value
//  m_*       out  m_tvalid/m_tready  tdata = angle
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One beat is accepted per clock when the output is not stalled. Stages:
// input, 17 divider stages, square, three Horner steps, final multiply,
// unfold, scale. The whole pipe advances together on one enable.
// When m_tready is low with a result waiting, every stage holds.
// rst is synchronous; it clears valid bits and resets the config registers.
`include "fast_atan2_degrees_unit_defines.svh"
module fast_atan2_degrees_unit #(
  parameter int COMPONENT_BITS = fa2d_pkg::COMPONENT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x_value [CB-1:0], y_value [2CB-1:CB], zero fill to bytes
  input  logic [((2*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // angle [23:0]
  output logic [fa2d_pkg::OUT_W-1:0] m_tdata,
  input  logic cfg_we,
  input  logic [fa2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fa2d_pkg::COEF_W-1:0] cfg_data
);

  localparam int CB = COMPONENT_BITS;
  localparam int FB = fa2d_pkg::FRAC_BITS;
  localparam int TW = fa2d_pkg::T_W;
  localparam int CW = fa2d_pkg::COEF_W;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // configuration registers
  logic signed [CW-1:0] p1, p3, p5, p7;
  logic [CW-1:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1    <= fa2d_pkg::P1_RST;
      p3    <= fa2d_pkg::P3_RST;
      p5    <= fa2d_pkg::P5_RST;
      p7    <= fa2d_pkg::P7_RST;
      scale <= fa2d_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (fa2d_pkg::cfg_reg_t'(cfg_index))
        fa2d_pkg::REG_P1:    p1 <= cfg_data;
        fa2d_pkg::REG_P3:    p3 <= cfg_data;
        fa2d_pkg::REG_P5:    p5 <= cfg_data;
        fa2d_pkg::REG_P7:    p7 <= cfg_data;
        fa2d_pkg::REG_SCALE: scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: magnitudes, swap, octant flags
  logic [CB-1:0] xin, yin, ax, ay;
  fa2d_pkg::flags_t fl_in;
  assign xin = s_tdata[CB-1:0];
  assign yin = s_tdata[2*CB-1:CB];
  assign ax  = xin[CB-1] ? (~xin + 1'b1) : xin;
  assign ay  = yin[CB-1] ? (~yin + 1'b1) : yin;
  always_comb begin
    fl_in.x_major = ax >= ay;
    fl_in.x_neg   = xin[CB-1];
    fl_in.y_neg   = yin[CB-1];
    fl_in.zero    = (ax == '0) && (ay == '0);
  end

  logic v0;
  logic [CB-1:0] lo0, hi0;
  fa2d_pkg::flags_t fl0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lo0 <= fl_in.x_major ? ay : ax;
      hi0 <= fl_in.x_major ? ax : ay;
      fl0 <= fl_in;
    end
  end

  logic vd;
  logic [fa2d_pkg::Q_BITS-1:0] qd;
  fa2d_pkg::flags_t fld;

  fa2d_divider #(.COMPONENT_BITS(COMPONENT_BITS)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(v0), .lo(lo0), .hi(hi0), .in_flags(fl0),
    .out_valid(vd), .quot(qd), .out_flags(fld)
  );

  // ratio with saturation and zero guard, then its square
  logic [FB-1:0] c_d;
  logic [2*FB-1:0] csq;
  assign c_d = fld.zero ? '0 : (qd[FB] ? fa2d_pkg::C_MAX : qd[FB-1:0]);
  assign csq = c_d * c_d;

  logic vm0;
  logic [FB-1:0] c0, c20;
  fa2d_pkg::flags_t flm0;
  always_ff @(posedge clk) begin
    if (rst) vm0 <= 1'b0;
    else if (adv) vm0 <= vd;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c0   <= c_d;
      c20  <= csq[2*FB-1:FB];
      flm0 <= fld;
    end
  end

  // Horner step 1: p7*c2 + p5
  logic signed [CW+FB:0] pr1;
  assign pr1 = p7 * $signed({1'b0, c20});
  logic vm1;
  logic signed [TW-1:0] t1;
  logic [FB-1:0] c1, c21;
  fa2d_pkg::flags_t flm1;
  always_ff @(posedge clk) begin
    if (rst) vm1 <= 1'b0;
    else if (adv) vm1 <= vm0;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t1   <= TW'(pr1 >>> FB) + TW'(p5);
      c1   <= c0;
      c21  <= c20;
      flm1 <= flm0;
    end
  end

  // Horner step 2: t*c2 + p3
  logic signed [TW+FB:0] pr2;
  assign pr2 = t1 * $signed({1'b0, c21});
  logic vm2;
  logic signed [TW-1:0] t2;
  logic [FB-1:0] c2r, c22;
  fa2d_pkg::flags_t flm2;
  always_ff @(posedge clk) begin
    if (rst) vm2 <= 1'b0;
    else if (adv) vm2 <= vm1;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t2   <= TW'(pr2 >>> FB) + TW'(p3);
      c2r  <= c1;
      c22  <= c21;
      flm2 <= flm1;
    end
  end

  // Horner step 3: t*c2 + p1
  logic signed [TW+FB:0] pr3;
  assign pr3 = t2 * $signed({1'b0, c22});
  logic vm3;
  logic signed [TW-1:0] t3;
  logic [FB-1:0] c3;
  fa2d_pkg::flags_t flm3;
  always_ff @(posedge clk) begin
    if (rst) vm3 <= 1'b0;
    else if (adv) vm3 <= vm2;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t3   <= TW'(pr3 >>> FB) + TW'(p1);
      c3   <= c2r;
      flm3 <= flm2;
    end
  end

  // final odd factor: t*c
  logic signed [TW+FB:0] pr4;
  assign pr4 = t3 * $signed({1'b0, c3});
  logic vm4;
  logic signed [TW-1:0] a4;
  fa2d_pkg::flags_t flm4;
  always_ff @(posedge clk) begin
    if (rst) vm4 <= 1'b0;
    else if (adv) vm4 <= vm3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a4   <= TW'(pr4 >>> FB);
      flm4 <= flm3;
    end
  end

  // unfold the octant and clamp at zero
  logic signed [fa2d_pkg::A_W-1:0] v_oct;
  logic [fa2d_pkg::AU_W-1:0] au_next;
  always_comb begin
    v_oct = fa2d_pkg::A_W'(a4);
    if (!flm4.x_major) v_oct = fa2d_pkg::DEG90 - v_oct;
    if (flm4.x_neg)    v_oct = fa2d_pkg::DEG180 - v_oct;
    if (flm4.y_neg)    v_oct = fa2d_pkg::DEG360 - v_oct;
    au_next = v_oct[fa2d_pkg::A_W-1] ? '0 : v_oct[fa2d_pkg::AU_W-1:0];
  end

  logic vf;
  logic [fa2d_pkg::AU_W-1:0] au;
  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (adv) vf <= vm4;
  end
  always_ff @(posedge clk) begin
    if (adv) au <= au_next;
  end

  // scale, drop 24 fraction bits, saturate
  logic [fa2d_pkg::AU_W+CW-1:0] prs;
  logic [fa2d_pkg::AU_W-1:0] rs;
  assign prs = au * scale;
  assign rs  = prs[fa2d_pkg::AU_W+CW-1:CW];

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= vf;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= (rs[fa2d_pkg::AU_W-1:fa2d_pkg::OUT_W] != '0) ? fa2d_pkg::OUT_MAX
                                                               : rs[fa2d_pkg::OUT_W-1:0];
    end
  end

  `FA2D_ASSERT_IMPLY(a_zero_ratio, vm0 && flm0.zero, c0 == '0, "zero pair gave a nonzero ratio")
  `FA2D_ASSERT_IMPLY(a_square_le, vm0, c20 <= c0, "square of ratio exceeds ratio")
  `FA2D_ASSERT_IMPLY(a_scale_zero, m_tvalid && (scale == '0), m_tdata == '0, "zero scale gave nonzero angle")

endmodule
